/* hdl/nfci_pkg.sv */
// Shared types, constants and command codes of the NOR flash command interface.
package nfci_pkg;

  localparam int ARRAY_WORDS = 262144;
  localparam int ADDR_W      = $clog2(ARRAY_WORDS);
  localparam int BOUND_W     = ADDR_W + 1;
  localparam int IN_ADDR_W   = 18;
  localparam int DATA_W      = 16;
  localparam int ERR_W       = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MAIN_BLOCK  = 65536;
  localparam int TOP_BASE    = (ARRAY_WORDS > MAIN_BLOCK) ? ARRAY_WORDS - MAIN_BLOCK : 0;

  localparam logic [BOUND_W-1:0] TOP_BASE_B   = BOUND_W'(TOP_BASE);
  localparam logic [BOUND_W-1:0] MAIN_BLOCK_B = BOUND_W'(MAIN_BLOCK);
  localparam logic [BOUND_W-1:0] MAIN_MASK_B  = ~BOUND_W'(MAIN_BLOCK - 1);
  localparam logic [BOUND_W-1:0] SPLIT_A_B    = BOUND_W'(32'h0000_C000);
  localparam logic [BOUND_W-1:0] SPLIT_B_B    = BOUND_W'(32'h0000_D000);
  localparam logic [BOUND_W-1:0] SPLIT_C_B    = BOUND_W'(32'h0000_E000);
  localparam logic [BOUND_W-1:0] ARRAY_END_B  = BOUND_W'(ARRAY_WORDS);
  localparam logic [ADDR_W-1:0]  ARRAY_LAST_A = ADDR_W'(ARRAY_WORDS - 1);

  // Command bytes
  localparam logic [7:0] CMD_ARRAY_MODE  = 8'hFF;
  localparam logic [7:0] CMD_STATUS_MODE = 8'h70;
  localparam logic [7:0] CMD_IDENT_MODE  = 8'h90;
  localparam logic [7:0] CMD_CLEAR_STAT  = 8'h50;
  localparam logic [7:0] CMD_PROGRAM     = 8'h40;
  localparam logic [7:0] CMD_BLOCK_ERASE = 8'h20;
  localparam logic [7:0] CMD_CONFIRM     = 8'hD0;

  localparam logic [DATA_W-1:0] ID_MANUFACTURER = 16'h0089;
  localparam logic [DATA_W-1:0] ID_DEVICE       = 16'h4470;
  localparam logic [DATA_W-1:0] READY_STATUS    = 16'h0080;
  localparam logic [DATA_W-1:0] ERASED_WORD     = 16'hFFFF;
  localparam logic [DATA_W-1:0] ZERO_WORD       = 16'h0000;

  localparam logic [ERR_W-1:0] ERR_ERASE = 3'b100;
  localparam logic [ERR_W-1:0] ERR_PROG  = 3'b010;
  localparam logic [ERR_W-1:0] ERR_VPP   = 3'b001;

  typedef enum logic [1:0] {
    KIND_CONST,
    KIND_READ,
    KIND_PROG,
    KIND_ERASE
  } nfci_kind_t;

  // One classified operation handed from the front to the back.
  typedef struct packed {
    nfci_kind_t         kind;
    logic [ADDR_W-1:0]  addr;
    logic [BOUND_W-1:0] hi;
    logic [DATA_W-1:0]  data;
  } nfci_op_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } nfci_qstat_t;

endpackage

/* hdl/nfci_front.sv */
// Front end: command state machine that classifies each bus word into an operation.
module nfci_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            operation,
  input  logic [nfci_pkg::IN_ADDR_W-1:0]  word_address,
  input  logic [nfci_pkg::DATA_W-1:0]     write_data,
  input  logic                            vpp_ok,
  output logic                            push,
  output nfci_pkg::nfci_op_t              op
);
  import nfci_pkg::*;

  typedef enum logic [2:0] {
    MODE_ARRAY,
    MODE_STATUS,
    MODE_ID,
    MODE_PROG_WAIT,
    MODE_ERASE_WAIT
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [ADDR_W-1:0]  addr;
  logic [7:0]         cmd;
  logic [BOUND_W-1:0] addr_b, off, lo, hi;
  logic [DATA_W-1:0]  status;

  assign addr   = ADDR_W'(word_address);
  assign cmd    = write_data[7:0];
  assign addr_b = BOUND_W'(addr);
  assign off    = addr_b - TOP_BASE_B;
  assign status = READY_STATUS | (DATA_W'(err_r) << 3);
  assign push   = accept;

  // Bounds of the erase block that holds the address; the top region is split.
  always_comb begin
    lo = '0;
    hi = '0;
    if (addr_b < TOP_BASE_B) begin
      lo = addr_b & MAIN_MASK_B;
      hi = lo + MAIN_BLOCK_B;
      if (hi > TOP_BASE_B) begin
        hi = TOP_BASE_B;
      end
    end else begin
      priority if (off < SPLIT_A_B) begin
        lo = '0;
        hi = SPLIT_A_B;
      end else if (off < SPLIT_B_B) begin
        lo = SPLIT_A_B;
        hi = SPLIT_B_B;
      end else if (off < SPLIT_C_B) begin
        lo = SPLIT_B_B;
        hi = SPLIT_C_B;
      end else begin
        lo = SPLIT_C_B;
        hi = MAIN_BLOCK_B;
      end
      lo = lo + TOP_BASE_B;
      hi = hi + TOP_BASE_B;
    end
    if (hi > ARRAY_END_B) begin
      hi = ARRAY_END_B;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    err_nxt  = err_r;
    op.kind  = KIND_CONST;
    op.addr  = addr;
    op.hi    = hi;
    op.data  = ZERO_WORD;
    if (!operation) begin
      unique case (mode_r)
        MODE_ARRAY: op.kind = KIND_READ;
        MODE_ID: begin
          if (word_address == '0) begin
            op.data = ID_MANUFACTURER;
          end else if (word_address == IN_ADDR_W'(1)) begin
            op.data = ID_DEVICE;
          end
        end
        default: op.data = status;
      endcase
    end else if (mode_r == MODE_PROG_WAIT) begin
      if (vpp_ok) begin
        op.kind = KIND_PROG;
        op.data = write_data;
      end else begin
        err_nxt = err_r | ERR_PROG | ERR_VPP;
      end
      mode_nxt = MODE_STATUS;
    end else if (mode_r == MODE_ERASE_WAIT) begin
      if (cmd != CMD_CONFIRM) begin
        err_nxt = err_r | ERR_ERASE;
      end else if (!vpp_ok) begin
        err_nxt = err_r | ERR_ERASE | ERR_VPP;
      end else begin
        op.kind = KIND_ERASE;
        op.addr = lo[ADDR_W-1:0];
      end
      mode_nxt = MODE_STATUS;
    end else begin
      unique case (cmd)
        CMD_ARRAY_MODE:  mode_nxt = MODE_ARRAY;
        CMD_STATUS_MODE: mode_nxt = MODE_STATUS;
        CMD_IDENT_MODE:  mode_nxt = MODE_ID;
        CMD_CLEAR_STAT:  err_nxt  = '0;
        CMD_PROGRAM:     mode_nxt = MODE_PROG_WAIT;
        CMD_BLOCK_ERASE: mode_nxt = MODE_ERASE_WAIT;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ARRAY;
      err_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

/* hdl/nfci_queue.sv */
// Short queue of classified operations between the front and the back.
module nfci_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  nfci_pkg::nfci_op_t    push_op,
  input  logic                  pop,
  output nfci_pkg::nfci_op_t    head_op,
  output nfci_pkg::nfci_qstat_t stat
);
  import nfci_pkg::*;

  nfci_op_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_op        = slot_r[rd_ptr_r];
  assign stat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.not_empty = (count_r != '0);

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/nfci_back.sv */
// Back end: flash array memory, clearing pass, reads, programs and block erase sweeps.
module nfci_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  input  nfci_pkg::nfci_op_t          op,
  output logic                        pop,
  output logic                        clearing,
  output logic                        res_valid,
  output logic [nfci_pkg::DATA_W-1:0] res_data
);
  import nfci_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PROG,
    ST_ERASE
  } state_t;

  logic [DATA_W-1:0]  mem_r [ARRAY_WORDS];
  logic [DATA_W-1:0]  rd_data_r;

  state_t             state_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [BOUND_W-1:0] hi_r;
  logic [DATA_W-1:0]  data_r;
  logic               res_valid_r;
  logic [DATA_W-1:0]  res_data_r;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0]  mem_wdata;

  assign pop       = (state_r == ST_IDLE) && op_valid;
  assign clearing  = (state_r == ST_CLEAR);
  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;
  assign mem_raddr = op.addr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = ERASED_WORD;
    unique case (state_r)
      ST_CLEAR, ST_ERASE: mem_we = 1'b1;
      ST_PROG: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r & data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[mem_raddr];
  end

  // addr_r walks the whole array after reset and each erase block afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          addr_r <= addr_r + ADDR_W'(1);
          if (addr_r == ARRAY_LAST_A) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (op_valid) begin
            addr_r <= op.addr;
            hi_r   <= op.hi;
            data_r <= op.data;
            unique case (op.kind)
              KIND_CONST: begin
                res_valid_r <= 1'b1;
                res_data_r  <= op.data;
              end
              KIND_READ:  state_r <= ST_READ;
              KIND_PROG:  state_r <= ST_PROG;
              KIND_ERASE: state_r <= ST_ERASE;
            endcase
          end
        end
        ST_READ: begin
          res_valid_r <= 1'b1;
          res_data_r  <= rd_data_r;
          state_r     <= ST_IDLE;
        end
        ST_PROG: begin
          res_valid_r <= 1'b1;
          res_data_r  <= ZERO_WORD;
          state_r     <= ST_IDLE;
        end
        ST_ERASE: begin
          addr_r <= addr_r + ADDR_W'(1);
          if (BOUND_W'(addr_r) + BOUND_W'(1) == hi_r) begin
            res_valid_r <= 1'b1;
            res_data_r  <= ZERO_WORD;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/nor_flash_command_interface_unit.sv */
// Top level of the NOR flash command interface: front end, operation queue and back end.
//
// A bus word is taken when start is high and busy is low; each word gives one result
// word on out_read_data, marked by out_valid for exactly one cycle, which the receiver
// must take then. After reset the array is swept to all ones, one word a cycle, while
// busy stays high. The array memory has one write and one read port and the back end
// works on one operation at a time: a status, ID or write-command word gives its result
// in the cycle after it leaves the queue, an array read or a program passes the memory
// read register and its own state, and a block erase writes each word of the block
// (4096 to 65536 words) before its result. The two-entry queue takes further words while
// the back end is working; busy rises when it is full.
module nor_flash_command_interface_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [nfci_pkg::IN_ADDR_W-1:0]  in_word_address,
  input  logic [nfci_pkg::DATA_W-1:0]     in_write_data,
  input  logic                            in_vpp_ok,
  output logic                            out_valid,
  output logic [nfci_pkg::DATA_W-1:0]     out_read_data
);
  import nfci_pkg::*;

  logic        accept, push, pop, clearing;
  nfci_op_t    push_op, head_op;
  nfci_qstat_t qstat;

  assign busy   = clearing | qstat.full;
  assign accept = start & ~busy;

  nfci_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .operation    (in_operation),
    .word_address (in_word_address),
    .write_data   (in_write_data),
    .vpp_ok       (in_vpp_ok),
    .push         (push),
    .op           (push_op)
  );

  nfci_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (qstat)
  );

  nfci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (qstat.not_empty),
    .op        (head_op),
    .pop       (pop),
    .clearing  (clearing),
    .res_valid (out_valid),
    .res_data  (out_read_data)
  );

endmodule

/* tb/sv/nor_flash_command_interface_unit_test.sv */
// Self-checking testbench for the NOR flash command interface: directed and random bus words.
`timescale 1ns / 1ps

module nor_flash_command_interface_unit_test;
  import nfci_pkg::*;

  localparam int RANDOM_WORDS   = 1125;
  localparam int TAIL_WORDS     = 150;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 800000;
  localparam int ERASE_BUDGET   = 240000;
  localparam int HOT_COUNT      = 16;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Offsets of the small blocks inside the top 64K-word region.
  localparam int SPLIT_A = 32'h0000_C000;
  localparam int SPLIT_B = 32'h0000_D000;
  localparam int SPLIT_C = 32'h0000_E000;

  localparam logic [7:0] CMD_UNKNOWN = 8'hB0;

  typedef enum logic [2:0] {
    FM_READ_ARRAY,
    FM_READ_STATUS,
    FM_READ_ID,
    FM_PROGRAM_WAIT,
    FM_ERASE_WAIT
  } flash_mode_t;

  typedef struct packed {
    logic                 drain;
    logic                 op;
    logic [IN_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]    data;
    logic                 vpp;
  } bus_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = 1'b0;
  logic [IN_ADDR_W-1:0] in_word_address = '0;
  logic [DATA_W-1:0]    in_write_data = '0;
  logic                 in_vpp_ok = 1'b0;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_read_data;

  // Predicted device state.
  logic [DATA_W-1:0] flash_mem [ARRAY_WORDS];
  flash_mode_t       flash_mode;
  logic [ERR_W-1:0]  err_bits;

  bus_word_t         pending_words[$];
  logic [DATA_W-1:0] expected_read_data[$];
  logic [IN_ADDR_W-1:0] hot_addr [HOT_COUNT];

  bus_word_t         cur_word;
  bus_word_t         head_word;
  logic [DATA_W-1:0] want;
  logic              took;
  logic              idling_on = 1'b1;
  logic              drain_next = 1'b0;
  int                gap_left = 0;
  int                word_total = 0;
  int                words_accepted = 0;
  int                reads_sent = 0;
  int                results_checked = 0;
  int                programs_done = 0;
  int                erases_done = 0;
  int                erased_words = 0;
  int                fail_count = 0;
  int                stall_cycles = 0;

  nor_flash_command_interface_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_word_address (in_word_address),
    .in_write_data   (in_write_data),
    .in_vpp_ok       (in_vpp_ok),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void block_bounds(input int a, output int lo, output int hi);
    int off;
    if (a < TOP_BASE) begin
      lo = a & ~(MAIN_BLOCK - 1);
      hi = lo + MAIN_BLOCK;
      if (hi > TOP_BASE) hi = TOP_BASE;
    end else begin
      off = a - TOP_BASE;
      if (off < SPLIT_A) begin
        lo = 0;       hi = SPLIT_A;
      end else if (off < SPLIT_B) begin
        lo = SPLIT_A; hi = SPLIT_B;
      end else if (off < SPLIT_C) begin
        lo = SPLIT_B; hi = SPLIT_C;
      end else begin
        lo = SPLIT_C; hi = MAIN_BLOCK;
      end
      lo += TOP_BASE;
      hi += TOP_BASE;
    end
    if (hi > ARRAY_WORDS) hi = ARRAY_WORDS;
  endfunction

  // Advances the predicted device by one bus word and returns the result word it gives.
  function automatic logic [DATA_W-1:0] predict_read_data(input bus_word_t w);
    int                a;
    int                lo;
    int                hi;
    logic [7:0]        cmd;
    logic [DATA_W-1:0] r;
    a   = int'(w.addr) % ARRAY_WORDS;
    cmd = w.data[7:0];
    r   = ZERO_WORD;
    if (w.op == OP_READ) begin
      case (flash_mode)
        FM_READ_ARRAY: r = flash_mem[a];
        FM_READ_ID: begin
          if (w.addr == 0) r = ID_MANUFACTURER;
          else if (w.addr == 1) r = ID_DEVICE;
          else r = ZERO_WORD;
        end
        default: r = READY_STATUS | (DATA_W'(err_bits) << 3);
      endcase
    end else if (flash_mode == FM_PROGRAM_WAIT) begin
      if (w.vpp) begin
        flash_mem[a] = flash_mem[a] & w.data;
        programs_done++;
      end else begin
        err_bits = err_bits | ERR_PROG | ERR_VPP;
      end
      flash_mode = FM_READ_STATUS;
    end else if (flash_mode == FM_ERASE_WAIT) begin
      if (cmd != CMD_CONFIRM) begin
        err_bits = err_bits | ERR_ERASE;
      end else if (!w.vpp) begin
        err_bits = err_bits | ERR_ERASE | ERR_VPP;
      end else begin
        block_bounds(a, lo, hi);
        for (int i = lo; i < hi; i++) flash_mem[i] = ERASED_WORD;
        erases_done++;
        erased_words += hi - lo;
      end
      flash_mode = FM_READ_STATUS;
    end else begin
      case (cmd)
        CMD_ARRAY_MODE:  flash_mode = FM_READ_ARRAY;
        CMD_STATUS_MODE: flash_mode = FM_READ_STATUS;
        CMD_IDENT_MODE:  flash_mode = FM_READ_ID;
        CMD_CLEAR_STAT:  err_bits = '0;
        CMD_PROGRAM:     flash_mode = FM_PROGRAM_WAIT;
        CMD_BLOCK_ERASE: flash_mode = FM_ERASE_WAIT;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic add_word(input logic op, input logic [IN_ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data, input logic vpp);
    bus_word_t w;
    w.drain = drain_next || ($urandom_range(0, 149) == 0);
    w.op    = op;
    w.addr  = addr;
    w.data  = data;
    w.vpp   = vpp;
    drain_next = 1'b0;
    pending_words.push_back(w);
  endtask

  function automatic logic [IN_ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return IN_ADDR_W'($urandom_range(0, 1));
      1, 2:    return hot_addr[$urandom_range(0, HOT_COUNT - 1)];
      default: return IN_ADDR_W'($urandom);
    endcase
  endfunction

  // Driver: presents one word at a time and predicts its result once it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        expected_read_data.push_back(predict_read_data(cur_word));
        words_accepted++;
        if (cur_word.op == OP_READ) reads_sent++;
        if (idling_on && words_accepted + TAIL_WORDS < word_total &&
            $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 18);
        if ($urandom_range(0, 63) == 0) idling_on = !idling_on;
      end
      if (pending_words.size() != 0) head_word = pending_words[0];
      if (start && !took) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (head_word.drain && (out_valid || expected_read_data.size() != 0)) begin
        // Hold the next word back until every outstanding result has come out.
        start <= 1'b0;
      end else begin
        cur_word = pending_words.pop_front();
        start           <= 1'b1;
        in_operation    <= cur_word.op;
        in_word_address <= cur_word.addr;
        in_write_data   <= cur_word.data;
        in_vpp_ok       <= cur_word.vpp;
      end
    end
  end

  // Monitor: every result word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_read_data.size() == 0) begin
        $error("read_data: expected no result word, got %04h", out_read_data);
        fail_count++;
      end else begin
        want = expected_read_data.pop_front();
        results_checked++;
        if (out_read_data !== want) begin
          $error("read_data: expected %04h, got %04h", want, out_read_data);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int                   kind;
    int                   lo;
    int                   hi;
    int                   budget;
    int                   n;
    logic                 vpp;
    logic                 good;
    logic [IN_ADDR_W-1:0] a;
    logic [DATA_W-1:0]    d;

    for (int i = 0; i < ARRAY_WORDS; i++) flash_mem[i] = ERASED_WORD;
    flash_mode = FM_READ_ARRAY;
    err_bits   = '0;

    hot_addr[0]  = '0;
    hot_addr[1]  = '1;
    hot_addr[2]  = IN_ADDR_W'(TOP_BASE - 1);
    hot_addr[3]  = IN_ADDR_W'(TOP_BASE);
    hot_addr[4]  = IN_ADDR_W'(TOP_BASE + SPLIT_A - 1);
    hot_addr[5]  = IN_ADDR_W'(TOP_BASE + SPLIT_A);
    hot_addr[6]  = IN_ADDR_W'(TOP_BASE + SPLIT_B - 1);
    hot_addr[7]  = IN_ADDR_W'(TOP_BASE + SPLIT_B);
    hot_addr[8]  = IN_ADDR_W'(TOP_BASE + SPLIT_C - 1);
    hot_addr[9]  = IN_ADDR_W'(TOP_BASE + SPLIT_C);
    hot_addr[10] = IN_ADDR_W'(MAIN_BLOCK - 1);
    hot_addr[11] = IN_ADDR_W'(MAIN_BLOCK);
    for (int i = 12; i < HOT_COUNT; i++) hot_addr[i] = IN_ADDR_W'($urandom);

    // Directed opening: address extremes, ID words, program and erase with their errors.
    add_word(OP_READ,  '0, 16'h0000, 1'b1);
    add_word(OP_READ,  '1, 16'hFFFF, 1'b0);
    add_word(OP_WRITE, '0, {8'h00, CMD_IDENT_MODE}, 1'b1);
    add_word(OP_READ,  IN_ADDR_W'(0), '0, 1'b1);
    add_word(OP_READ,  IN_ADDR_W'(1), '0, 1'b1);
    add_word(OP_READ,  '1, '0, 1'b1);
    add_word(OP_WRITE, 18'h3D010, {8'h00, CMD_PROGRAM}, 1'b1);
    add_word(OP_WRITE, 18'h3D010, 16'h0F0F, 1'b1);
    add_word(OP_READ,  18'h3D010, '0, 1'b1);
    add_word(OP_WRITE, '0, {8'hFF, CMD_ARRAY_MODE}, 1'b1);
    add_word(OP_READ,  18'h3D010, '0, 1'b1);
    add_word(OP_WRITE, 18'h00123, {8'h00, CMD_PROGRAM}, 1'b1);
    add_word(OP_WRITE, 18'h00123, 16'h0000, 1'b0);
    add_word(OP_READ,  18'h00123, '0, 1'b1);
    add_word(OP_WRITE, 18'h3D000, {8'h00, CMD_BLOCK_ERASE}, 1'b1);
    add_word(OP_WRITE, 18'h3D000, {8'h00, CMD_ARRAY_MODE}, 1'b1);
    add_word(OP_WRITE, '0, {8'hA5, CMD_CLEAR_STAT}, 1'b1);
    add_word(OP_WRITE, 18'h3D000, {8'h00, CMD_BLOCK_ERASE}, 1'b1);
    add_word(OP_WRITE, 18'h3D000, {8'h00, CMD_CONFIRM}, 1'b0);
    add_word(OP_WRITE, '0, {8'h00, CMD_CONFIRM}, 1'b1);
    add_word(OP_WRITE, '0, {8'h00, CMD_UNKNOWN}, 1'b1);
    drain_next = 1'b1;
    add_word(OP_WRITE, 18'h3DFFF, {8'h00, CMD_BLOCK_ERASE}, 1'b1);
    add_word(OP_WRITE, 18'h3DFFF, {8'hFF, CMD_CONFIRM}, 1'b1);
    add_word(OP_WRITE, '0, {8'h00, CMD_STATUS_MODE}, 1'b1);
    add_word(OP_READ,  '0, '0, 1'b1);
    add_word(OP_WRITE, '0, 16'hFFFF, 1'b1);
    add_word(OP_READ,  18'h3D010, '0, 1'b1);

    budget = ERASE_BUDGET;
    n = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        add_word(OP_READ, pick_addr(), DATA_W'($urandom), 1'($urandom));
      end else if (kind < 30) begin
        case ($urandom_range(0, 2))
          0:       d = {8'($urandom), CMD_ARRAY_MODE};
          1:       d = {8'($urandom), CMD_STATUS_MODE};
          default: d = {8'($urandom), CMD_IDENT_MODE};
        endcase
        add_word(OP_WRITE, IN_ADDR_W'($urandom), d, 1'($urandom));
        repeat ($urandom_range(1, 3)) add_word(OP_READ, pick_addr(), DATA_W'($urandom), 1'b1);
      end else if (kind < 55) begin
        a = hot_addr[$urandom_range(0, HOT_COUNT - 1)];
        add_word(OP_WRITE, IN_ADDR_W'($urandom), {8'($urandom), CMD_PROGRAM}, 1'($urandom));
        add_word(OP_WRITE, a, DATA_W'($urandom), $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 1) == 1) begin
          add_word(OP_WRITE, IN_ADDR_W'($urandom), {8'($urandom), CMD_ARRAY_MODE}, 1'b1);
          add_word(OP_READ, a, '0, 1'b1);
        end else begin
          add_word(OP_READ, pick_addr(), '0, 1'b1);
        end
      end else if (kind < 70) begin
        if ($urandom_range(0, 3) != 0)
          a = IN_ADDR_W'(TOP_BASE + $urandom_range(SPLIT_A, MAIN_BLOCK - 1));
        else
          a = IN_ADDR_W'($urandom);
        vpp  = $urandom_range(0, 6) != 0;
        good = $urandom_range(0, 4) != 0;
        // Real erases are costly, so they draw on a fixed budget of words.
        if (good && vpp) begin
          block_bounds(int'(a) % ARRAY_WORDS, lo, hi);
          if (budget >= hi - lo) budget -= hi - lo;
          else good = 1'b0;
        end
        if (good) begin
          d = {8'($urandom), CMD_CONFIRM};
        end else begin
          d = DATA_W'($urandom);
          if (d[7:0] == CMD_CONFIRM) d[0] = ~d[0];
        end
        add_word(OP_WRITE, IN_ADDR_W'($urandom), {8'($urandom), CMD_BLOCK_ERASE}, 1'($urandom));
        add_word(OP_WRITE, a, d, vpp);
        add_word(OP_READ, pick_addr(), '0, 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          add_word(OP_WRITE, '0, {8'($urandom), CMD_ARRAY_MODE}, 1'b1);
          add_word(OP_READ, a, '0, 1'b1);
        end
      end else if (kind < 80) begin
        add_word(OP_WRITE, IN_ADDR_W'($urandom), {8'($urandom), CMD_CLEAR_STAT}, 1'($urandom));
        add_word(OP_READ, pick_addr(), '0, 1'b1);
      end else begin
        add_word(1'($urandom), IN_ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
      end
    end
    word_total = pending_words.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted < word_total || expected_read_data.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d bus words (%0d reads), %0d result words checked",
             words_accepted, reads_sent, results_checked);
    $display("programs applied: %0d, block erases: %0d over %0d array words",
             programs_done, erases_done, erased_words);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
